// ===== design/adam_pkg.sv =====
`default_nettype none
package adam_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int RATE_W    = 24;
    localparam int SLOT_W    = 12;
    localparam int DATA_W    = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE_RATE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_DECAY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_DECAY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_DECAY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GUARD_TERM   = 3'd4;

    localparam logic [RATE_W-1:0] RST_BASE_RATE    = 24'd16777;
    localparam logic [RATE_W-1:0] RST_FIRST_DECAY  = 24'd15099494;
    localparam logic [RATE_W-1:0] RST_SECOND_DECAY = 24'd16760439;
    localparam logic [RATE_W-1:0] RST_RATE_DECAY   = 24'd0;
    localparam logic [RATE_W-1:0] RST_GUARD_TERM   = 24'd2;

    localparam logic [24:0]        ONE_Q24   = 25'h100_0000;
    localparam logic signed [67:0] HALF_Q24  = 68'sd8388608;
    localparam logic signed [67:0] MAX_S32   = 68'sd2147483647;
    localparam logic signed [67:0] MIN_S32   = -68'sd2147483648;
    localparam logic signed [67:0] MAX_U32   = 68'sd4294967295;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_E_M1, ST_E_M2, ST_E_M3, ST_E_M4, ST_E_M5, ST_E_M6, ST_E_M7, ST_E_M8,
        ST_E_SQ, ST_E_DV, ST_E_OUT,
        ST_P_R1, ST_P_R2, ST_P_R3, ST_P_P1, ST_P_P2, ST_P_P3,
        ST_P_C1, ST_P_C2, ST_P_C3, ST_P_C4
    } state_t;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic        start;
        logic [55:0] value;
    } sq_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [27:0] root;
    } sq_rsp_t;

    function automatic logic signed [31:0] sat_s32(input logic signed [67:0] x);
        if (x > MAX_S32) return 32'sh7fff_ffff;
        if (x < MIN_S32) return 32'sh8000_0000;
        return x[31:0];
    endfunction

    function automatic logic [31:0] sat_u32(input logic signed [67:0] x);
        if (x > MAX_U32) return 32'hffff_ffff;
        return x[31:0];
    endfunction

endpackage
`default_nettype wire

// ===== design/adam_if.sv =====
`default_nettype none
interface adam_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [11:0]        slot;
    logic signed [31:0] gradient;
    logic signed [31:0] param_value;
    modport source (output valid, kind, slot, gradient, param_value, input ready);
    modport sink (input valid, kind, slot, gradient, param_value, output ready);
endinterface

interface adam_out_if;
    logic               valid;
    logic               ready;
    logic [11:0]        out_slot;
    logic signed [31:0] new_value;
    modport source (output valid, out_slot, new_value, input ready);
    modport sink (input valid, out_slot, new_value, output ready);
endinterface

interface adam_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/adam_optimizer_update_top.sv =====
// Adam update engine. A kind 0 word starts a new pass: the step count advances, the
// beta powers are updated and the pass rate and both bias corrections are recomputed;
// it returns nothing and runs up to three divisions.
// A kind 1 word updates the moments of its slot in the on-chip store and returns the
// new parameter after work on the shared multiplier, in the bit-pair square root and
// in the one-bit-a-cycle divider. One word is in work at a time; the next is taken
// while a result still waits in the output register. A slot at or above STORE_DEPTH
// is dropped without a result. After reset a clearing pass zeroes every entry of the
// moment store, during which no word is taken; configuration writes are accepted at
// any time and should only be made while idle.
`default_nettype none
module adam_optimizer_update_top #(
    parameter int STORE_DEPTH = 4096
) (
    input wire logic   clk,
    input wire logic   rst_n,
    adam_in_if.sink    din,
    adam_out_if.source dout,
    adam_cfg_if.sink   cfg
);
    import adam_pkg::*;

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    // configuration registers
    logic [23:0] base_rate_reg;
    logic [23:0] first_decay_reg;
    logic [23:0] second_decay_reg;
    logic [23:0] rate_decay_reg;
    logic [23:0] guard_term_reg;

    // pass state
    logic [31:0] step_count_reg;
    logic [24:0] first_power_reg;
    logic [24:0] second_power_reg;
    logic [31:0] first_corr_reg;
    logic [31:0] second_corr_reg;
    logic [23:0] pass_rate_reg;

    // word being worked on
    logic               kind_reg;
    logic [11:0]        slot_reg;
    logic [AW-1:0]      addr_reg;
    logic signed [31:0] grad_reg;
    logic signed [31:0] param_reg;
    logic signed [31:0] m_new_reg;
    logic [31:0]        c_new_reg;
    logic [31:0]        sq_reg;
    logic signed [31:0] mh_reg;
    logic signed [67:0] acc_reg;

    // shared multiplier
    logic               mul_en;
    logic signed [33:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [67:0] prod_reg;

    // clearing pass
    logic          clr_active_reg;
    logic [AW-1:0] clr_addr_reg;

    // output register
    logic               out_valid_reg;
    logic [11:0]        out_slot_reg;
    logic signed [31:0] new_value_reg;

    state_t state_reg;
    state_t state_next;

    div_req_t div_req;
    div_rsp_t div_rsp;
    sq_req_t  sq_req;
    sq_rsp_t  sq_rsp;

    logic          in_ready;
    logic          in_acc;
    logic          slot_ok;
    logic          out_free;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [63:0]   mem_wdata;
    logic [63:0]   mem_rdata;
    logic [AW-1:0] in_addr;

    // moment values read back from the store
    logic signed [31:0] m_old;
    logic [31:0]        c_old;
    logic [24:0]        one_minus_b1;
    logic [24:0]        one_minus_b2;
    logic [28:0]        den_raw;
    logic [28:0]        den;
    logic signed [67:0] nmag;
    logic signed [67:0] step_val;

    assign m_old        = mem_rdata[63:32];
    assign c_old        = mem_rdata[31:0];
    assign one_minus_b1 = ONE_Q24 - {1'b0, first_decay_reg};
    assign one_minus_b2 = ONE_Q24 - {1'b0, second_decay_reg};

    // root plus guard, one ulp when both are zero
    assign den_raw = {1'b0, sq_rsp.root} + {5'd0, guard_term_reg};
    assign den     = (den_raw == '0) ? 29'd1 : den_raw;
    assign nmag    = prod_reg[67] ? -prod_reg : prod_reg;
    assign step_val = prod_reg[67] ? -$signed({4'd0, div_rsp.quotient})
                                   : $signed({4'd0, div_rsp.quotient});

    assign in_acc   = din.valid && in_ready;
    assign slot_ok  = {20'd0, din.slot} < 32'(STORE_DEPTH);
    assign in_addr  = AW'({20'd0, din.slot});
    assign out_free = !out_valid_reg || dout.ready;

    assign din.ready      = in_ready;
    assign cfg.ready      = 1'b1;
    assign dout.valid     = out_valid_reg;
    assign dout.out_slot  = out_slot_reg;
    assign dout.new_value = new_value_reg;

    adam_ram #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (64)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (in_acc),
        .raddr (in_addr),
        .rdata (mem_rdata)
    );

    adam_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    adam_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sq_req),
        .rsp   (sq_rsp)
    );

    // configuration writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_rate_reg    <= RST_BASE_RATE;
            first_decay_reg  <= RST_FIRST_DECAY;
            second_decay_reg <= RST_SECOND_DECAY;
            rate_decay_reg   <= RST_RATE_DECAY;
            guard_term_reg   <= RST_GUARD_TERM;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_BASE_RATE:    base_rate_reg    <= cfg.data;
                REG_FIRST_DECAY:  first_decay_reg  <= cfg.data;
                REG_SECOND_DECAY: second_decay_reg <= cfg.data;
                REG_RATE_DECAY:   rate_decay_reg   <= cfg.data;
                REG_GUARD_TERM:   guard_term_reg   <= cfg.data;
                default:          ;
            endcase
        end
    end

    // clearing pass over the moment store after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(STORE_DEPTH - 1))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (!din.kind)
                    begin
                        state_next = ST_P_R1;
                    end
                    else if (slot_ok)
                    begin
                        state_next = ST_E_M1;
                    end
                end
            end
            ST_E_M1:  state_next = ST_E_M2;
            ST_E_M2:  state_next = ST_E_M3;
            ST_E_M3:  state_next = ST_E_M4;
            ST_E_M4:  state_next = ST_E_M5;
            ST_E_M5:  state_next = ST_E_M6;
            ST_E_M6:  state_next = ST_E_M7;
            ST_E_M7:  state_next = ST_E_M8;
            ST_E_M8:  state_next = ST_E_SQ;
            ST_E_SQ:  state_next = sq_rsp.done ? ST_E_DV : ST_E_SQ;
            ST_E_DV:  state_next = div_rsp.done ? ST_E_OUT : ST_E_DV;
            ST_E_OUT: state_next = out_free ? ST_IDLE : ST_E_OUT;
            ST_P_R1:  state_next = (rate_decay_reg == '0) ? ST_P_P1 : ST_P_R2;
            ST_P_R2:  state_next = ST_P_R3;
            ST_P_R3:  state_next = div_rsp.done ? ST_P_P1 : ST_P_R3;
            ST_P_P1:  state_next = ST_P_P2;
            ST_P_P2:  state_next = ST_P_P3;
            ST_P_P3:  state_next = ST_P_C1;
            ST_P_C1:  state_next = (first_power_reg >= ONE_Q24) ? ST_P_C3 : ST_P_C2;
            ST_P_C2:  state_next = div_rsp.done ? ST_P_C3 : ST_P_C2;
            ST_P_C3:  state_next = (second_power_reg >= ONE_Q24) ? ST_IDLE : ST_P_C4;
            ST_P_C4:  state_next = div_rsp.done ? ST_IDLE : ST_P_C4;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control outputs and multiplier operands
    always_comb
    begin
        in_ready         = 1'b0;
        mul_en           = 1'b0;
        mul_a            = '0;
        mul_b            = '0;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = 64'd1;
        sq_req.start     = 1'b0;
        sq_req.value     = '0;
        mem_we           = clr_active_reg;
        mem_waddr        = clr_active_reg ? clr_addr_reg : addr_reg;
        mem_wdata        = clr_active_reg ? 64'd0 : {m_new_reg, c_new_reg};
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = !clr_active_reg;
            end
            ST_E_M1:
            begin
                mul_en = 1'b1;
                mul_a  = {{2{m_old[31]}}, m_old};
                mul_b  = {10'd0, first_decay_reg};
            end
            ST_E_M2:
            begin
                mul_en = 1'b1;
                mul_a  = {{2{grad_reg[31]}}, grad_reg};
                mul_b  = {9'd0, one_minus_b1};
            end
            ST_E_M3:
            begin
                // the square of -g equals the square of g
                mul_en = 1'b1;
                mul_a  = {{2{grad_reg[31]}}, grad_reg};
                mul_b  = {{2{grad_reg[31]}}, grad_reg};
            end
            ST_E_M4:
            begin
                mul_en = 1'b1;
                mul_a  = {2'd0, c_old};
                mul_b  = {10'd0, second_decay_reg};
            end
            ST_E_M5:
            begin
                mul_en = 1'b1;
                mul_a  = {2'd0, sq_reg};
                mul_b  = {9'd0, one_minus_b2};
            end
            ST_E_M6:
            begin
                mul_en = 1'b1;
                mul_a  = {{2{m_new_reg[31]}}, m_new_reg};
                mul_b  = {2'd0, first_corr_reg};
            end
            ST_E_M7:
            begin
                mem_we = 1'b1;
                mul_en = 1'b1;
                mul_a  = {2'd0, c_new_reg};
                mul_b  = {2'd0, second_corr_reg};
            end
            ST_E_M8:
            begin
                sq_req.start = 1'b1;
                sq_req.value = {sat_u32((prod_reg + HALF_Q24) >>> 24), 24'd0};
                mul_en = 1'b1;
                mul_a  = {10'd0, pass_rate_reg};
                mul_b  = {{2{mh_reg[31]}}, mh_reg};
            end
            ST_E_SQ:
            begin
                if (sq_rsp.done)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = nmag[63:0] + {36'd0, den[28:1]};
                    div_req.divisor  = {35'd0, den};
                end
            end
            ST_P_R1:
            begin
                mul_en = 1'b1;
                mul_a  = {10'd0, rate_decay_reg};
                mul_b  = {2'd0, step_count_reg};
            end
            ST_P_R2:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {16'd0, base_rate_reg, 24'd0};
                div_req.divisor  = {39'd0, ONE_Q24} + prod_reg[63:0];
            end
            ST_P_P1:
            begin
                mul_en = 1'b1;
                mul_a  = {9'd0, first_power_reg};
                mul_b  = {10'd0, first_decay_reg};
            end
            ST_P_P2:
            begin
                mul_en = 1'b1;
                mul_a  = {9'd0, second_power_reg};
                mul_b  = {10'd0, second_decay_reg};
            end
            ST_P_C1:
            begin
                if (first_power_reg < ONE_Q24)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = 64'h0001_0000_0000_0000;
                    div_req.divisor  = {39'd0, ONE_Q24 - first_power_reg};
                end
            end
            ST_P_C3:
            begin
                if (second_power_reg < ONE_Q24)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = 64'h0001_0000_0000_0000;
                    div_req.divisor  = {39'd0, ONE_Q24 - second_power_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
    end

    // word registers and element datapath
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            kind_reg  <= din.kind;
            slot_reg  <= din.slot;
            addr_reg  <= in_addr;
            grad_reg  <= din.gradient;
            param_reg <= din.param_value;
        end
        case (state_reg)
            ST_E_M2: acc_reg   <= prod_reg + HALF_Q24;
            ST_E_M3: m_new_reg <= sat_s32((acc_reg + prod_reg) >>> 24);
            ST_E_M4: sq_reg    <= sat_u32((prod_reg + HALF_Q24) >>> 24);
            ST_E_M5: acc_reg   <= prod_reg + HALF_Q24;
            ST_E_M6: c_new_reg <= sat_u32((acc_reg + prod_reg) >>> 24);
            ST_E_M7: mh_reg    <= sat_s32((prod_reg + HALF_Q24) >>> 24);
            ST_E_DV:
            begin
                // signed step once the divider finishes
                if (div_rsp.done && kind_reg)
                begin
                    acc_reg <= step_val;
                end
            end
            default: ;
        endcase
    end

    // pass state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_count_reg   <= '0;
            first_power_reg  <= ONE_Q24;
            second_power_reg <= ONE_Q24;
            first_corr_reg   <= '0;
            second_corr_reg  <= '0;
            pass_rate_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                ST_P_R1:
                begin
                    if (rate_decay_reg == '0)
                    begin
                        pass_rate_reg <= base_rate_reg;
                    end
                end
                ST_P_R3:
                begin
                    if (div_rsp.done)
                    begin
                        pass_rate_reg <= div_rsp.quotient[23:0];
                    end
                end
                ST_P_P1:
                begin
                    step_count_reg <= step_count_reg + 32'd1;
                end
                ST_P_P2:
                begin
                    first_power_reg <= prod_reg[48:24] + {24'd0, prod_reg[23]};
                end
                ST_P_P3:
                begin
                    second_power_reg <= prod_reg[48:24] + {24'd0, prod_reg[23]};
                end
                ST_P_C1:
                begin
                    if (first_power_reg >= ONE_Q24)
                    begin
                        first_corr_reg <= 32'hffff_ffff;
                    end
                end
                ST_P_C2:
                begin
                    if (div_rsp.done)
                    begin
                        first_corr_reg <= (div_rsp.quotient[63:32] != '0) ? 32'hffff_ffff
                                                                         : div_rsp.quotient[31:0];
                    end
                end
                ST_P_C3:
                begin
                    if (second_power_reg >= ONE_Q24)
                    begin
                        second_corr_reg <= 32'hffff_ffff;
                    end
                end
                ST_P_C4:
                begin
                    if (div_rsp.done)
                    begin
                        second_corr_reg <= (div_rsp.quotient[63:32] != '0) ? 32'hffff_ffff
                                                                          : div_rsp.quotient[31:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_E_OUT && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (dout.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_E_OUT && out_free)
        begin
            out_slot_reg  <= slot_reg;
            new_value_reg <= sat_s32({{36{param_reg[31]}}, param_reg} - acc_reg);
        end
    end

    // no word is taken while the store is being cleared
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !din.ready)
        else $error("word accepted during clearing pass");

    // the divider is only started when idle
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");

    // the store is only written by the clearing pass or the write-back step
    a_store_write: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (clr_active_reg || state_reg == ST_E_M7))
        else $error("unexpected moment store write");

endmodule
`default_nettype wire

// ===== design/adam_ram.sv =====
`default_nettype none
module adam_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// ===== design/adam_div.sv =====
`default_nettype none
module adam_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire adam_pkg::div_req_t req,
    output adam_pkg::div_rsp_t      rsp
);
    import adam_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [6:0]  cnt_reg;
    logic [64:0] rem_reg;
    logic [63:0] quo_reg;
    logic [63:0] dvs_reg;
    logic [64:0] rem_sh;

    // restoring division, one quotient bit a cycle
    assign rem_sh = {rem_reg[63:0], quo_reg[63]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd63;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_reg <= rem_sh - {1'b0, dvs_reg};
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
endmodule
`default_nettype wire

// ===== design/adam_sqrt.sv =====
`default_nettype none
module adam_sqrt (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire adam_pkg::sq_req_t req,
    output adam_pkg::sq_rsp_t      rsp
);
    import adam_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [55:0] val_reg;
    logic [27:0] res_reg;
    logic [31:0] rem_reg;
    logic [31:0] rem_sh;
    logic [31:0] trial;

    // two radicand bits per cycle
    assign rem_sh = {rem_reg[29:0], val_reg[55:54]};
    assign trial  = {2'b00, res_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd27;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            val_reg <= req.value;
            res_reg <= '0;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            val_reg <= {val_reg[53:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg <= rem_sh - trial;
                res_reg <= {res_reg[26:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                res_reg <= {res_reg[26:0], 1'b0};
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.root = res_reg;
endmodule
`default_nettype wire

// ===== test/tb.sv =====
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import adam_pkg::*;

    localparam int DEPTH      = 4096;
    localparam int WATCH_MAX  = 20000;   // idle cycles before giving up
    localparam int SETTLE     = 300;     // longer than one pass word
    localparam int HOLD_LEN   = 600;     // long receiver hold-off
    localparam int PHASE_LEN  = 250;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic KIND_PASS = 1'b0;
    localparam logic KIND_ELEM = 1'b1;

    typedef logic signed [95:0] wide_t;
    localparam wide_t W_ONE  = 96'sd16777216;
    localparam wide_t W_HALF = 96'sd8388608;
    localparam wide_t W_SMAX = 96'sd2147483647;
    localparam wide_t W_SMIN = -96'sd2147483648;
    localparam wide_t W_UMAX = 96'sd4294967295;

    typedef struct {
        logic               kind;
        logic [11:0]        slot;
        logic signed [31:0] grad;
        logic signed [31:0] param;
    } adam_word_t;

    typedef struct {
        logic [11:0]        slot;
        logic signed [31:0] value;
    } update_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    adam_in_if  din_if ();
    adam_out_if dout_if ();
    adam_cfg_if cfg_if ();

    adam_optimizer_update_top #(.STORE_DEPTH(DEPTH)) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .din  (din_if),
        .dout (dout_if),
        .cfg  (cfg_if)
    );

    // predictor copy of configuration and state
    logic [23:0]        base_rate    = RST_BASE_RATE;
    logic [23:0]        first_decay  = RST_FIRST_DECAY;
    logic [23:0]        second_decay = RST_SECOND_DECAY;
    logic [23:0]        rate_decay   = RST_RATE_DECAY;
    logic [23:0]        guard_term   = RST_GUARD_TERM;
    logic signed [31:0] mom1 [DEPTH];
    logic [31:0]        mom2 [DEPTH];
    logic [31:0]        step_cnt = '0;
    logic [31:0]        pow1 = ONE_Q24;
    logic [31:0]        pow2 = ONE_Q24;
    logic [31:0]        corr1 = '0;
    logic [31:0]        corr2 = '0;
    logic [23:0]        pass_rate = '0;

    adam_word_t pend_words [$];
    update_t    expected_updates [$];

    int  errors = 0;
    int  words_in = 0;
    int  idle_cycles = 0;
    bit  calm = 1'b0;
    bit  stall_req = 1'b0;
    bit  stall_used = 1'b0;
    int  hold_cnt = 0;
    bit  in_fire_q = 1'b0;

    function automatic wide_t uwide(input logic [63:0] x);
        return $signed({32'b0, x});
    endfunction

    function automatic wide_t clip_s(input wide_t x);
        if (x > W_SMAX) return W_SMAX;
        if (x < W_SMIN) return W_SMIN;
        return x;
    endfunction

    function automatic wide_t clip_u(input wide_t x);
        return (x > W_UMAX) ? W_UMAX : x;
    endfunction

    function automatic logic [63:0] int_root(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = '0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] next_power(input logic [31:0] p, input logic [23:0] beta);
        wide_t t;
        t = (uwide(p) * uwide(beta) + W_HALF) >>> 24;
        return t[31:0];
    endfunction

    function automatic logic [31:0] bias_corr(input logic [31:0] p);
        wide_t t;
        if (p >= ONE_Q24) return 32'hffff_ffff;
        t = clip_u((W_ONE * W_ONE) / (W_ONE - uwide(p)));
        return t[31:0];
    endfunction

    // advance the model by one accepted word
    task automatic adam_predict(input adam_word_t w);
        wide_t   den, m, c, g, gm, sq, mh, ch, num, nm, q, stp, nv;
        logic [63:0] root;
        update_t r;
        if (w.kind == KIND_PASS)
        begin
            if (rate_decay == 0)
                pass_rate = base_rate;
            else
            begin
                den = W_ONE + uwide(rate_decay) * uwide(step_cnt);
                q = (uwide(base_rate) <<< 24) / den;
                pass_rate = q[23:0];
            end
            step_cnt = step_cnt + 1;
            pow1  = next_power(pow1, first_decay);
            pow2  = next_power(pow2, second_decay);
            corr1 = bias_corr(pow1);
            corr2 = bias_corr(pow2);
        end
        else if (w.slot < DEPTH)
        begin
            m  = mom1[w.slot];
            c  = uwide(mom2[w.slot]);
            g  = w.grad;
            gm = (g < 0) ? -g : g;
            sq = clip_u((gm * gm + W_HALF) >>> 24);
            m  = clip_s((m * uwide(first_decay) + g * (W_ONE - uwide(first_decay)) + W_HALF) >>> 24);
            c  = clip_u((c * uwide(second_decay) + sq * (W_ONE - uwide(second_decay)) + W_HALF)
                        >>> 24);
            mom1[w.slot] = m[31:0];
            mom2[w.slot] = c[31:0];
            mh   = clip_s((m * uwide(corr1) + W_HALF) >>> 24);
            ch   = clip_u((c * uwide(corr2) + W_HALF) >>> 24);
            root = int_root(ch[63:0] << 24);
            den  = uwide(root) + uwide(guard_term);
            // zero divisor becomes one ulp
            if (den == 0) den = 1;
            num = uwide(pass_rate) * mh;
            nm  = (num < 0) ? -num : num;
            q   = (nm + den / 2) / den;
            stp = (num < 0) ? -q : q;
            nv  = clip_s(wide_t'(w.param) - stp);
            r.slot  = w.slot;
            r.value = nv[31:0];
            expected_updates.push_back(r);
        end
    endtask

    // input driver: holds a word until it is taken, then maybe idles
    always @(negedge clk)
    begin
        if (!rst_n)
            din_if.valid <= 1'b0;
        else if (din_if.valid && !in_fire_q)
            din_if.valid <= 1'b1;
        else if (pend_words.size() > 0 && (calm || $urandom_range(99) >= 36))
        begin
            din_if.valid       <= 1'b1;
            din_if.kind        <= pend_words[0].kind;
            din_if.slot        <= pend_words[0].slot;
            din_if.gradient    <= pend_words[0].grad;
            din_if.param_value <= pend_words[0].param;
            void'(pend_words.pop_front());
        end
        else
            din_if.valid <= 1'b0;
    end

    // output ready: random stalls plus one long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            dout_if.ready <= 1'b0;
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            dout_if.ready <= 1'b0;
        end
        else if (stall_req && !stall_used)
        begin
            stall_used <= 1'b1;
            hold_cnt <= HOLD_LEN;
            dout_if.ready <= 1'b0;
        end
        else
            dout_if.ready <= calm || $urandom_range(99) >= 36;
    end

    // monitor: predict on accepted words, check accepted results
    always @(posedge clk)
    begin
        update_t  want;
        adam_word_t w;
        bit any;
        any = 1'b0;
        in_fire_q <= din_if.valid && din_if.ready;
        if (rst_n && cfg_if.valid && cfg_if.ready)
        begin
            any = 1'b1;
            case (cfg_if.index)
                REG_BASE_RATE:    base_rate    <= cfg_if.data;
                REG_FIRST_DECAY:  first_decay  <= cfg_if.data;
                REG_SECOND_DECAY: second_decay <= cfg_if.data;
                REG_RATE_DECAY:   rate_decay   <= cfg_if.data;
                REG_GUARD_TERM:   guard_term   <= cfg_if.data;
                default: ;
            endcase
        end
        if (rst_n && din_if.valid && din_if.ready)
        begin
            any = 1'b1;
            w.kind  = din_if.kind;
            w.slot  = din_if.slot;
            w.grad  = din_if.gradient;
            w.param = din_if.param_value;
            adam_predict(w);
            words_in <= words_in + 1;
        end
        if (rst_n && dout_if.valid && dout_if.ready)
        begin
            any = 1'b1;
            if (expected_updates.size() == 0)
            begin
                errors <= errors + 1;
                if (errors < 10)
                    $display("unexpected word: slot %0d value %0d",
                             dout_if.out_slot, dout_if.new_value);
            end
            else
            begin
                want = expected_updates.pop_front();
                if (dout_if.out_slot !== want.slot || dout_if.new_value !== want.value)
                begin
                    errors <= errors + 1;
                    if (errors < 10)
                        $display("mismatch: expected slot %0d value %0d, got slot %0d value %0d",
                                 want.slot, want.value, dout_if.out_slot, dout_if.new_value);
                end
            end
        end
        // watchdog on cycles with no handshake at all
        if (any)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCH_MAX)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic push_word(input logic kind, input logic [11:0] slot,
                             input logic [31:0] grad, input logic [31:0] param);
        adam_word_t w;
        w.kind  = kind;
        w.slot  = slot;
        w.grad  = grad;
        w.param = param;
        pend_words.push_back(w);
    endtask

    // wait for the block to go idle before touching registers
    task automatic drain();
        while (pend_words.size() > 0 || din_if.valid || expected_updates.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic write_all(input logic [23:0] br, input logic [23:0] b1, input logic [23:0] b2,
                             input logic [23:0] rd, input logic [23:0] gt);
        write_reg(REG_BASE_RATE, br);
        write_reg(REG_FIRST_DECAY, b1);
        write_reg(REG_SECOND_DECAY, b2);
        write_reg(REG_RATE_DECAY, rd);
        write_reg(REG_GUARD_TERM, gt);
    endtask

    // random traffic: mostly elements on a few hot slots, some passes
    task automatic random_words(input int n);
        logic [31:0] g;
        logic [11:0] s;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 10)
                push_word(KIND_PASS, 12'($urandom), $urandom, $urandom);
            else
            begin
                s = ($urandom_range(99) < 70) ? 12'($urandom_range(15)) : 12'($urandom);
                case ($urandom_range(3))
                    0: g = $urandom;
                    1: g = 32'($signed($urandom_range(2000)) - 1000);
                    default: g = 32'($signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000);
                endcase
                push_word(KIND_ELEM, s, g, $urandom);
            end
        end
    endtask

    initial
    begin
        foreach (mom1[i])
        begin
            mom1[i] = '0;
            mom2[i] = '0;
        end
        din_if.valid = 1'b0;
        din_if.kind = KIND_PASS;
        din_if.slot = '0;
        din_if.gradient = '0;
        din_if.param_value = '0;
        dout_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = REG_BASE_RATE;
        cfg_if.data = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // elements ahead of any pass keep their parameter
        push_word(KIND_ELEM, 12'd0, 32'h7fff_ffff, 32'h7fff_ffff);
        push_word(KIND_ELEM, 12'd4095, 32'h8000_0000, 32'h8000_0000);
        push_word(KIND_PASS, '0, '0, '0);
        push_word(KIND_ELEM, 12'd0, 32'h7fff_ffff, 32'h8000_0000);
        push_word(KIND_ELEM, 12'd4095, 32'h8000_0000, 32'h7fff_ffff);
        push_word(KIND_ELEM, 12'd1, 32'h0, 32'h0);
        push_word(KIND_ELEM, 12'd2, 32'h0100_0000, 32'h0100_0000);
        push_word(KIND_PASS, 12'hfff, 32'hffff_ffff, 32'hffff_ffff);
        push_word(KIND_ELEM, 12'd2, 32'hff00_0000, 32'hffff_ffff);
        push_word(KIND_ELEM, 12'd0, 32'h7fff_ffff, 32'h0);
        drain();

        // extreme settings; zero guard with an empty slot gives a zero divisor
        write_all(24'hff_ffff, 24'h0, 24'hff_ffff, 24'hff_ffff, 24'h0);
        write_reg(REG_UNUSED, 24'h12_3456);
        push_word(KIND_PASS, '0, '0, '0);
        push_word(KIND_ELEM, 12'd100, 32'd1000, 32'd5);
        push_word(KIND_ELEM, 12'd101, -32'sd1000, -32'sd5);
        push_word(KIND_ELEM, 12'd102, 32'd0, 32'd7);
        push_word(KIND_PASS, '0, '0, '0);
        push_word(KIND_ELEM, 12'd4095, 32'h7fff_ffff, 32'h8000_0000);
        push_word(KIND_ELEM, 12'd0, 32'h8000_0000, 32'h7fff_ffff);
        drain();

        write_all(24'h0, 24'hff_ffff, 24'h0, 24'h1, 24'hff_ffff);
        random_words(PHASE_LEN);
        drain();

        write_all(RST_BASE_RATE, RST_FIRST_DECAY, RST_SECOND_DECAY, RST_RATE_DECAY,
                  RST_GUARD_TERM);
        calm = 1'b1;
        random_words(PHASE_LEN);
        drain();
        calm = 1'b0;

        // long receiver hold-off while words keep coming
        write_all($urandom, $urandom, $urandom, 24'($urandom_range(4000)), $urandom_range(50));
        random_words(PHASE_LEN);
        repeat (50) @(posedge clk);
        stall_req = 1'b1;
        drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            write_all($urandom, $urandom_range(24'hff_ffff, 24'he0_0000),
                      $urandom_range(24'hff_ffff, 24'hf0_0000),
                      (ph == 0) ? 24'h0 : 24'($urandom), $urandom);
            random_words(PHASE_LEN);
            drain();
        end

        if (errors == 0 && expected_updates.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
